[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sfid_pkg.sv]
// Package of types, codes and constants for the sector fault injection decider.
package sfid_pkg;

  // Default width of the per-direction sequence counters.
  localparam int COUNT_WIDTH_DEF = 32;

  // Field widths fixed by the interface.
  localparam int SECTOR_W = 64;
  localparam int RANDOM_W = 32;
  localparam int FREQ_W   = 32;
  localparam int MODE_W   = 2;

  // Remainder unit sizing: dividend and divisor widths and the step counter.
  localparam int DVD_W = 64;
  localparam int DIV_W = 32;
  localparam int STEP_W = $clog2(DVD_W);

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_READ_ENABLE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_READ_MODE       = 3'd1;
  localparam logic [IDX_W-1:0] REG_READ_FREQUENCY  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WRITE_ENABLE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_WRITE_MODE      = 3'd4;
  localparam logic [IDX_W-1:0] REG_WRITE_FREQUENCY = 3'd5;

  // Decision modes; the fourth code never corrupts.
  localparam logic [MODE_W-1:0] MODE_MODULO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEQUENTIAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Input transaction.
  typedef struct packed {
    logic                func;
    logic [SECTOR_W-1:0] sector_number;
    logic [RANDOM_W-1:0] random_word;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic                corrupt;
    logic                was_write;
    logic [SECTOR_W-1:0] sector_out;
  } out_item_t;

  // Status of the remainder unit towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic is_zero;
  } rem_status_t;

endpackage

[hw/rtl/sfid_rem_unit.sv]
// Bit-serial restoring remainder unit: 64-bit dividend by a 32-bit divisor.
module sfid_rem_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sfid_pkg::DVD_W-1:0] dividend,
  input  logic [sfid_pkg::DIV_W-1:0] divisor,
  output sfid_pkg::rem_status_t     status
);

  logic                        busy_r;
  logic                        done_r;
  logic [sfid_pkg::STEP_W-1:0] step_r;
  logic [sfid_pkg::DVD_W-1:0]  dvd_r;
  logic [sfid_pkg::DIV_W-1:0]  div_r;
  logic [sfid_pkg::DIV_W:0]    rem_r;
  logic [sfid_pkg::DIV_W:0]    rem_sh;
  logic [sfid_pkg::DIV_W:0]    rem_nxt;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_r[sfid_pkg::DIV_W-1:0], dvd_r[sfid_pkg::DVD_W-1]};
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt = rem_sh - {1'b0, div_r};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  // Control: step counter, busy flag and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= sfid_pkg::STEP_W'(sfid_pkg::DVD_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[sfid_pkg::DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign status.busy    = busy_r;
  assign status.done    = done_r;
  assign status.is_zero = (rem_r == '0);

endmodule

[hw/rtl/sector_fault_injection_decider.sv]
// Top level of the sector fault injection decider: registers, counters and sequencer.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    func, sector_number, random_word
//  out_     output     out_valid / out_ready  corrupt, was_write, sector_out
//  cfg      input      psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// A transaction that needs a remainder runs in the shared remainder unit, which
// resolves one dividend bit per cycle over 64 bits, then waits in the hold state.
// A disabled direction or the unused mode goes from acceptance straight to the hold state.
// The finished result waits in the output register; a stalled output holds the
// sequencer only once the next result is ready. Reset (rst_n, synchronous) clears
// the configuration registers to their documented values and both counters to zero.
module sector_fault_injection_decider #(
  parameter int COUNT_WIDTH = sfid_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sfid_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sfid_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfid_pkg::ADDR_W-1:0] paddr,
  input  logic [sfid_pkg::DATA_W-1:0] pwdata,
  output logic [sfid_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  // Configuration registers.
  logic                        rd_en_r;
  logic [sfid_pkg::MODE_W-1:0] rd_mode_r;
  logic [sfid_pkg::FREQ_W-1:0] rd_freq_r;
  logic                        wr_en_r;
  logic [sfid_pkg::MODE_W-1:0] wr_mode_r;
  logic [sfid_pkg::FREQ_W-1:0] wr_freq_r;

  // Sequence counters.
  logic [COUNT_WIDTH-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [COUNT_WIDTH-1:0] wr_cnt_r, wr_cnt_nxt;

  // Sequencer and held transaction.
  sfid_pkg::state_t             state_r, state_nxt;
  logic                         func_r;
  logic [sfid_pkg::SECTOR_W-1:0] sector_r;
  logic                         corrupt_r, corrupt_nxt;
  logic                         out_valid_r;
  sfid_pkg::out_item_t          out_data_r;
  logic                         load_out;

  // Selection for the accepted transaction.
  logic                        in_acc;
  logic                        cfg_wr;
  logic [sfid_pkg::IDX_W-1:0]  cfg_idx;
  logic                        sel_en;
  logic [sfid_pkg::MODE_W-1:0] sel_mode;
  logic [sfid_pkg::FREQ_W-1:0] sel_freq;
  logic [COUNT_WIDTH-1:0]      sel_cnt_inc;
  logic                        skip;
  logic [sfid_pkg::DVD_W-1:0]  dividend;
  logic                        rem_start;
  sfid_pkg::rem_status_t       rem_st;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[sfid_pkg::ADDR_W-1:2];
  assign in_ready = (state_r == sfid_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      sfid_pkg::REG_READ_ENABLE:     prdata = {{(sfid_pkg::DATA_W-1){1'b0}}, rd_en_r};
      sfid_pkg::REG_READ_MODE:       prdata = {{(sfid_pkg::DATA_W-2){1'b0}}, rd_mode_r};
      sfid_pkg::REG_READ_FREQUENCY:  prdata = rd_freq_r;
      sfid_pkg::REG_WRITE_ENABLE:    prdata = {{(sfid_pkg::DATA_W-1){1'b0}}, wr_en_r};
      sfid_pkg::REG_WRITE_MODE:      prdata = {{(sfid_pkg::DATA_W-2){1'b0}}, wr_mode_r};
      sfid_pkg::REG_WRITE_FREQUENCY: prdata = wr_freq_r;
      default:                       prdata = '0;
    endcase
  end

  // Configuration writes; a zero frequency is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_en_r   <= 1'b0;
      rd_mode_r <= sfid_pkg::MODE_RANDOM;
      rd_freq_r <= sfid_pkg::FREQ_W'(1);
      wr_en_r   <= 1'b0;
      wr_mode_r <= sfid_pkg::MODE_RANDOM;
      wr_freq_r <= sfid_pkg::FREQ_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        sfid_pkg::REG_READ_ENABLE:  rd_en_r   <= pwdata[0];
        sfid_pkg::REG_READ_MODE:    rd_mode_r <= pwdata[sfid_pkg::MODE_W-1:0];
        sfid_pkg::REG_READ_FREQUENCY: begin
          if (pwdata != '0) rd_freq_r <= pwdata;
        end
        sfid_pkg::REG_WRITE_ENABLE: wr_en_r   <= pwdata[0];
        sfid_pkg::REG_WRITE_MODE:   wr_mode_r <= pwdata[sfid_pkg::MODE_W-1:0];
        sfid_pkg::REG_WRITE_FREQUENCY: begin
          if (pwdata != '0) wr_freq_r <= pwdata;
        end
        default: ;
      endcase
    end
  end

  // Pick the settings of the transaction's direction.
  always_comb begin
    if (in_data.func) begin
      sel_en      = wr_en_r;
      sel_mode    = wr_mode_r;
      sel_freq    = wr_freq_r;
      sel_cnt_inc = wr_cnt_r + 1'b1;
    end else begin
      sel_en      = rd_en_r;
      sel_mode    = rd_mode_r;
      sel_freq    = rd_freq_r;
      sel_cnt_inc = rd_cnt_r + 1'b1;
    end
    skip = !sel_en || (sel_mode == sfid_pkg::MODE_UNUSED);
    case (sel_mode)
      sfid_pkg::MODE_MODULO:     dividend = in_data.sector_number;
      sfid_pkg::MODE_RANDOM:     dividend = sfid_pkg::DVD_W'(in_data.random_word);
      sfid_pkg::MODE_SEQUENTIAL: dividend = sfid_pkg::DVD_W'(sel_cnt_inc);
      default:                   dividend = '0;
    endcase
  end

  assign rem_start = in_acc && !skip;

  // Counters: cleared by the documented writes, stepped by a sequential decision.
  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    wr_cnt_nxt = wr_cnt_r;
    if (cfg_wr) begin
      case (cfg_idx)
        sfid_pkg::REG_READ_ENABLE: begin
          if (pwdata[0]) rd_cnt_nxt = '0;
        end
        sfid_pkg::REG_READ_MODE: begin
          if (pwdata[sfid_pkg::MODE_W-1:0] == sfid_pkg::MODE_SEQUENTIAL) rd_cnt_nxt = '0;
        end
        sfid_pkg::REG_READ_FREQUENCY: begin
          if (pwdata != '0) rd_cnt_nxt = '0;
        end
        sfid_pkg::REG_WRITE_ENABLE: begin
          if (pwdata[0]) wr_cnt_nxt = '0;
        end
        sfid_pkg::REG_WRITE_MODE: begin
          if (pwdata[sfid_pkg::MODE_W-1:0] == sfid_pkg::MODE_SEQUENTIAL) wr_cnt_nxt = '0;
        end
        sfid_pkg::REG_WRITE_FREQUENCY: begin
          if (pwdata != '0) wr_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
    if (rem_start && (sel_mode == sfid_pkg::MODE_SEQUENTIAL)) begin
      if (in_data.func) begin
        wr_cnt_nxt = sel_cnt_inc;
      end else begin
        rd_cnt_nxt = sel_cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      wr_cnt_r <= '0;
    end else begin
      rd_cnt_r <= rd_cnt_nxt;
      wr_cnt_r <= wr_cnt_nxt;
    end
  end

  // Shared remainder unit.
  sfid_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (dividend),
    .divisor  (sel_freq),
    .status   (rem_st)
  );

  // Sequencer: next state and result capture.
  always_comb begin
    state_nxt   = state_r;
    corrupt_nxt = corrupt_r;
    load_out    = 1'b0;
    case (state_r)
      sfid_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (skip) begin
            corrupt_nxt = 1'b0;
            state_nxt   = sfid_pkg::ST_HOLD;
          end else begin
            state_nxt = sfid_pkg::ST_RUN;
          end
        end
      end
      sfid_pkg::ST_RUN: begin
        if (rem_st.done) begin
          corrupt_nxt = rem_st.is_zero;
          state_nxt   = sfid_pkg::ST_HOLD;
        end
      end
      sfid_pkg::ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = sfid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Held transaction fields.
  always_ff @(posedge clk) begin
    corrupt_r <= corrupt_nxt;
    if (in_acc) begin
      func_r   <= in_data.func;
      sector_r <= in_data.sector_number;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.corrupt    <= corrupt_r;
      out_data_r.was_write  <= func_r;
      out_data_r.sector_out <= sector_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/sfid_checker.sv]
// Port-level checker for the sector fault injection decider, with its bind.
`include "assert_macros.svh"

module sfid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sfid_pkg::out_item_t out_data,
  input logic                pready
);

  // A stalled result keeps its valid and its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // The block works on one transaction at a time.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

  // No result can appear in the cycle right after an input is taken into an empty block.
  `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid, "result appeared too early")

  // The configuration port never inserts wait states.
  `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready, "pready dropped")

endmodule

bind sector_fault_injection_decider sfid_checker u_sfid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

[verif/tb_sector_fault_injection_decider.sv]
// Self-checking testbench for the sector fault injection decider.
`timescale 1ns / 100ps

module tb_sector_fault_injection_decider;
  import sfid_pkg::*;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 50;
  localparam int DRAIN_CYCLES = 80;

  // Predicts each decision from its own copy of the registers and counters,
  // and holds the decisions still to come out of the block.
  class decision_board;
    logic                       enable [2];
    logic [MODE_W-1:0]          mode [2];
    logic [FREQ_W-1:0]          frequency [2];
    logic [COUNT_WIDTH_DEF-1:0] seq_count [2];
    out_item_t                  expected_decisions [$];
    int                         errors;

    function new();
      for (int d = 0; d < 2; d++) begin
        enable[d]    = 1'b0;
        mode[d]      = MODE_RANDOM;
        frequency[d] = 1;
        seq_count[d] = '0;
      end
      errors = 0;
    endfunction

    // Mirrors one register write, including the counter clearing rules.
    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      bit d;
      d = (idx == REG_WRITE_ENABLE) || (idx == REG_WRITE_MODE) ||
          (idx == REG_WRITE_FREQUENCY);
      case (idx)
        REG_READ_ENABLE, REG_WRITE_ENABLE: begin
          if (value[0]) seq_count[d] = '0;
          enable[d] = value[0];
        end
        REG_READ_MODE, REG_WRITE_MODE: begin
          if (value[MODE_W-1:0] == MODE_SEQUENTIAL) seq_count[d] = '0;
          mode[d] = value[MODE_W-1:0];
        end
        REG_READ_FREQUENCY, REG_WRITE_FREQUENCY: begin
          // A zero divisor is refused and leaves the counter alone.
          if (value != 0) begin
            seq_count[d] = '0;
            frequency[d] = value;
          end
        end
        default: ;
      endcase
    endfunction

    // Works out whether a sector is corrupted; sequential mode advances the counter.
    function bit predict_corrupt(bit d, logic [SECTOR_W-1:0] sector,
                                 logic [RANDOM_W-1:0] rnd);
      logic [63:0] divisor;
      divisor = 64'(frequency[d]);
      if (!enable[d] || frequency[d] == 0) return 1'b0;
      case (mode[d])
        MODE_MODULO: return (sector % divisor) == 0;
        MODE_RANDOM: return (64'(rnd) % divisor) == 0;
        MODE_SEQUENTIAL: begin
          seq_count[d] = seq_count[d] + 1'b1;
          return (64'(seq_count[d]) % divisor) == 0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      e.corrupt    = predict_corrupt(it.func, it.sector_number, it.random_word);
      e.was_write  = it.func;
      e.sector_out = it.sector_number;
      expected_decisions.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_decisions.size() == 0) begin
        $error("sector_out: unexpected result %h with no decision pending",
               got.sector_out);
        errors++;
        return;
      end
      e = expected_decisions.pop_front();
      if (got.corrupt !== e.corrupt) begin
        $error("corrupt: expected %0d, actual %0d", e.corrupt, got.corrupt);
        errors++;
      end
      if (got.was_write !== e.was_write) begin
        $error("was_write: expected %0d, actual %0d", e.was_write, got.was_write);
        errors++;
      end
      if (got.sector_out !== e.sector_out) begin
        $error("sector_out: expected %h, actual %h", e.sector_out, got.sector_out);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_decisions.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  decision_board board = new();
  bit            no_idle = 1'b0;

  sector_fault_injection_decider dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Transactions on both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  // Result side back-pressure: random stalls, with out_ready raised again between any two.
  initial begin : ready_gen
    int hold_left;
    int stall;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          hold_left = stall - 1;
        end
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the input channel until the block has returned every decision.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // Drains the block and lets it fall idle before registers change.
  task automatic settle();
    wait_drained();
    repeat (4) @(negedge clk);
  endtask

  // Offers one transaction and returns at the falling edge after it is taken.
  task automatic send_access(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic access(input bit func, input logic [SECTOR_W-1:0] sector,
                        input logic [RANDOM_W-1:0] rnd);
    in_item_t it;
    it.func          = func;
    it.sector_number = sector;
    it.random_word   = rnd;
    send_access(it);
    idle_sender();
  endtask

  // Random access, often aimed at multiples of the current divisor.
  function automatic in_item_t make_access();
    in_item_t         it;
    logic [FREQ_W-1:0] f;
    it.func = 1'($urandom_range(0, 1));
    f = board.frequency[it.func];
    case ($urandom_range(0, 3))
      0: it.sector_number = 64'($urandom_range(0, 999));
      1: it.sector_number = 64'($urandom) * 64'(f);
      default: it.sector_number = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 2))
      0: it.random_word = 32'(64'($urandom_range(0, 7)) * 64'(f));
      1: it.random_word = $urandom_range(0, 99);
      default: it.random_word = $urandom;
    endcase
    return it;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_frequency();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      3: return $urandom;
      4: return 2;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_UNUSED;
    if (r < 5) return MODE_SEQUENTIAL;
    if (r < 8) return MODE_RANDOM;
    return MODE_MODULO;
  endfunction

  // Upper data bits are ignored by the block, so they are sometimes set at random.
  function automatic logic [DATA_W-1:0] noisy_word();
    return ($urandom_range(0, 3) == 0) ? $urandom : '0;
  endfunction

  // Rewrites a direction's registers; each write may be skipped unless forced.
  task automatic configure_direction(input bit d, input bit every_reg);
    logic [DATA_W-1:0] v;
    if (every_reg || $urandom_range(0, 9) < 7) begin
      v = noisy_word();
      v[0] = ($urandom_range(0, 9) < 8);
      cfg_write(d ? REG_WRITE_ENABLE : REG_READ_ENABLE, v);
    end
    if (every_reg || $urandom_range(0, 9) < 7) begin
      v = noisy_word();
      v[MODE_W-1:0] = pick_mode();
      cfg_write(d ? REG_WRITE_MODE : REG_READ_MODE, v);
    end
    if (every_reg || $urandom_range(0, 9) < 7)
      cfg_write(d ? REG_WRITE_FREQUENCY : REG_READ_FREQUENCY, pick_frequency());
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    in_item_t it;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Both directions are disabled after reset.
    access(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    access(1'b1, 64'd0, 32'hFFFF_FFFF);

    // Modulo of the sector number.
    settle();
    cfg_write(REG_READ_ENABLE, 32'd1);
    cfg_write(REG_READ_MODE, MODE_MODULO);
    cfg_write(REG_READ_FREQUENCY, 32'd3);
    access(1'b0, 64'd0, 32'd7);
    access(1'b0, 64'd3, 32'd7);
    access(1'b0, 64'd4, 32'd0);
    access(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);

    // Random mode with the largest divisor; upper data bits are ignored.
    settle();
    cfg_write(REG_WRITE_ENABLE, 32'hFFFF_FFFF);
    cfg_write(REG_WRITE_MODE, 32'h0000_0005);
    cfg_write(REG_WRITE_FREQUENCY, 32'hFFFF_FFFF);
    access(1'b1, 64'd1, 32'd0);
    access(1'b1, 64'd2, 32'hFFFF_FFFF);
    access(1'b1, 64'd3, 32'd5);

    // Sequential count; a zero divisor write keeps the count running.
    settle();
    cfg_write(REG_READ_MODE, MODE_SEQUENTIAL);
    cfg_write(REG_READ_FREQUENCY, 32'd2);
    access(1'b0, 64'd10, 32'd0);
    access(1'b0, 64'd11, 32'd0);
    access(1'b0, 64'd12, 32'd0);
    settle();
    cfg_write(REG_READ_FREQUENCY, 32'd0);
    access(1'b0, 64'd13, 32'd0);

    // Disabling stops the counter; re-enabling clears it.
    settle();
    cfg_write(REG_READ_ENABLE, 32'd2);
    access(1'b0, 64'd14, 32'd0);
    settle();
    cfg_write(REG_READ_ENABLE, 32'd1);
    access(1'b0, 64'd15, 32'd0);

    // The unused mode never corrupts; unmapped indexes change nothing.
    settle();
    cfg_write(REG_WRITE_MODE, MODE_UNUSED);
    cfg_write(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    access(1'b1, 64'd0, 32'd0);
    access(1'b0, 64'd16, 32'd0);

    // Divisor of one, and modulo by the largest divisor on 64-bit sectors.
    settle();
    cfg_write(REG_READ_MODE, MODE_MODULO);
    cfg_write(REG_READ_FREQUENCY, 32'd1);
    cfg_write(REG_WRITE_MODE, MODE_MODULO);
    access(1'b0, {$urandom, $urandom}, $urandom);
    access(1'b1, 64'h0000_0000_FFFF_FFFF, 32'd3);
    access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3);
    access(1'b1, 64'h0000_0001_0000_0000, 32'd3);

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      no_idle = (p % 4 == 3);
      configure_direction(1'b0, p == 0);
      configure_direction(1'b1, p == 0);
      if ($urandom_range(0, 5) == 0)
        cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        it = make_access();
        send_access(it);
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
        else idle_sender();
      end
    end

    // Let every decision come out, then watch for stray results.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sfid_pkg.sv
hw/rtl/sfid_rem_unit.sv
hw/rtl/sector_fault_injection_decider.sv
hw/rtl/sfid_checker.sv
verif/tb_sector_fault_injection_decider.sv
